@@ rtl/iqd_pkg.sv @@
// shared types, constants and the arctangent table for the iq demodulator
`timescale 1ns / 1ps
package iqd_pkg;

	// mode register codes
	localparam logic [2:0] MODE_NONE = 3'd0;
	localparam logic [2:0] MODE_AM   = 3'd1;
	localparam logic [2:0] MODE_FM   = 3'd2;
	localparam logic [2:0] MODE_LSB  = 3'd3;
	localparam logic [2:0] MODE_USB  = 3'd4;

	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 24;
	localparam int OPND_W   = 33;
	localparam int VEC_W    = 48;
	localparam int ANG_W    = 36;
	localparam int STEPS    = 30;
	localparam int ROOT_W   = 16;
	localparam int DEFAULT_BLOCK_LEN = 1024;

	localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;

	// work kinds for the back end
	typedef enum logic [1:0] {
		OP_PASS  = 2'd0,
		OP_MAG   = 2'd1,
		OP_ANGLE = 2'd2
	} op_t;

	// one queued request from front to back
	typedef struct packed {
		op_t                      op;
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
	} job_t;

	// arctangent of 2^-i in Q6.30 radians
	function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
		logic signed [ANG_W-1:0] v;
		begin
			case (idx)
				5'd0:  v = 36'sd843314857;
				5'd1:  v = 36'sd497837830;
				5'd2:  v = 36'sd263043837;
				5'd3:  v = 36'sd133525159;
				5'd4:  v = 36'sd67021687;
				5'd5:  v = 36'sd33543516;
				5'd6:  v = 36'sd16775851;
				5'd7:  v = 36'sd8388437;
				5'd8:  v = 36'sd4194283;
				5'd9:  v = 36'sd2097149;
				5'd10: v = 36'sd1048576;
				5'd11: v = 36'sd524288;
				5'd12: v = 36'sd262144;
				5'd13: v = 36'sd131072;
				5'd14: v = 36'sd65536;
				5'd15: v = 36'sd32768;
				5'd16: v = 36'sd16384;
				5'd17: v = 36'sd8192;
				5'd18: v = 36'sd4096;
				5'd19: v = 36'sd2048;
				5'd20: v = 36'sd1024;
				5'd21: v = 36'sd512;
				5'd22: v = 36'sd256;
				5'd23: v = 36'sd128;
				5'd24: v = 36'sd64;
				5'd25: v = 36'sd32;
				5'd26: v = 36'sd16;
				5'd27: v = 36'sd8;
				5'd28: v = 36'sd4;
				5'd29: v = 36'sd2;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

@@ rtl/multimode_iq_demodulator.sv @@
// top level of the multimode am, fm and sideband iq demodulator
`timescale 1ns / 1ps
// Complex baseband samples enter on the s_axis channel (tdata holds I in the
// low half, Q in the high half). One demodulated sample per input leaves on
// m_axis in the selected mode; mode none drops inputs. tlast marks the last
// sample of every BLOCK_LEN outputs.
// The mode register is written through cfg_we/cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce.
// A write also clears the previous sample and the block position. The front
// end takes an input every cycle in mode none; otherwise it passes through
// its push state (after product states F_MUL1 and F_MUL2, each forming two
// 16x16 products, for AM and FM) before taking the next. The back end runs
// one request at a time: AM forms one root bit per cycle, FM runs normalizing
// shifts plus 30 cordic rotations unless its product is zero. A two-entry
// queue sits between the two sides; sustained rate is set by the back end.
// Reset clears the mode to none, the previous sample and block position,
// and empties the queue and output register. When the receiver stalls the
// result waits in the output register, the back end holds its finished
// result, the queue fills and then s_axis_tready drops.
module multimode_iq_demodulator import iqd_pkg::*; #(
	parameter int BLOCK_LEN = DEFAULT_BLOCK_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // i_sample [15:0], q_sample [31:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // sample_out [23:0]
	output logic        m_axis_tlast
);

	logic [2:0] mode_q;
	logic       push, full, pop, empty;
	job_t       wr_job, rd_job;
	logic signed [OUT_W-1:0] out_data;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_NONE;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	iqd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.mode     (mode_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_i     (s_axis_tdata[15:0]),
		.in_q     (s_axis_tdata[31:16]),
		.push     (push),
		.full     (full),
		.job      (wr_job)
	);

	iqd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_job (rd_job)
	);

	iqd_back #(.BLOCK_LEN(BLOCK_LEN)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.empty     (empty),
		.job       (rd_job),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = out_data;

endmodule

@@ rtl/iqd_front.sv @@
// front end: accepts samples, forms products and queues work for the back end
`timescale 1ns / 1ps
module iqd_front import iqd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 mode,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] in_i,
	input  logic signed [SAMPLE_W-1:0] in_q,
	output logic                       push,
	input  logic                       full,
	output job_t                       job
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL1 = 4'b0010,
		F_MUL2 = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;
	logic [2:0] mode_q;
	logic signed [SAMPLE_W-1:0] si_q, sq_q, pa_q, pb_q, prev_i_q, prev_q_q;
	logic signed [2*SAMPLE_W-1:0] p1_q, p2_q, p3_q, p4_q;
	logic accept;

	assign in_ready = (state_q == F_IDLE);
	assign accept   = in_valid && in_ready;
	assign push     = (state_q == F_PUSH) && !full;

	// control and previous sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			prev_i_q <= '0;
			prev_q_q <= '0;
		end else if (cfg_we) begin
			prev_i_q <= '0;
			prev_q_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (mode == MODE_AM || mode == MODE_FM) begin
							state_q <= F_MUL1;
						end else if (mode == MODE_LSB || mode == MODE_USB) begin
							state_q <= F_PUSH;
						end
						if (mode == MODE_FM) begin
							prev_i_q <= in_i;
							prev_q_q <= in_q;
						end
					end
				end
				F_MUL1: state_q <= F_MUL2;
				F_MUL2: state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// sample capture and products
	always_ff @(posedge clk) begin
		if (accept) begin
			si_q   <= in_i;
			sq_q   <= in_q;
			pa_q   <= prev_i_q;
			pb_q   <= prev_q_q;
			mode_q <= mode;
		end
		if (state_q == F_MUL1) begin
			if (mode_q == MODE_AM) begin
				p1_q <= si_q * si_q;
				p2_q <= sq_q * sq_q;
			end else begin
				p1_q <= si_q * pa_q;
				p2_q <= sq_q * pb_q;
			end
		end
		if (state_q == F_MUL2) begin
			p3_q <= sq_q * pa_q;
			p4_q <= si_q * pb_q;
		end
	end

	// build the queued request
	always_comb begin
		job.a  = OPND_W'(p1_q) + OPND_W'(p2_q);
		job.b  = OPND_W'(p3_q) - OPND_W'(p4_q);
		job.op = OP_PASS;
		case (mode_q)
			MODE_AM:  job.op = OP_MAG;
			MODE_FM:  job.op = OP_ANGLE;
			MODE_LSB: job.a  = OPND_W'(si_q) - OPND_W'(sq_q);
			MODE_USB: job.a  = OPND_W'((OPND_W'(si_q) + OPND_W'(sq_q)) * OPND_W'(100));
			default:  job.op = OP_PASS;
		endcase
	end

endmodule

@@ rtl/iqd_fifo.sv @@
// two-entry request queue between front and back end
`timescale 1ns / 1ps
module iqd_fifo import iqd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t rd_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

@@ rtl/iqd_back.sv @@
// back end: square root and cordic angle units plus output register
`timescale 1ns / 1ps
module iqd_back import iqd_pkg::*; #(
	parameter int BLOCK_LEN = DEFAULT_BLOCK_LEN
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    empty,
	input  job_t                    job,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] out_data,
	output logic                    out_last
);

	localparam int CNT_W = $clog2(BLOCK_LEN) + 1;
	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BLOCK_LEN - 1);

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_SQRT = 5'b00010,
		B_NORM = 5'b00100,
		B_ROT  = 5'b01000,
		B_DONE = 5'b10000
	} bstate_t;

	bstate_t state_q;
	logic signed [VEC_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [4:0]              step_q;
	logic [31:0]             rad_q;
	logic [19:0]             rem_q;
	logic [ROOT_W-1:0]       root_q;
	logic signed [OUT_W-1:0] res_q;
	logic [CNT_W-1:0]        pos_q;
	logic                    load_out;

	// cordic and root step logic
	logic signed [VEC_W-1:0] xs, ys, ax, ay, mag;
	logic signed [ANG_W-1:0] z_next, z_rnd;
	logic [19:0]             rem2;
	logic [19:0]             trial;

	always_comb begin
		xs     = x_q >>> step_q;
		ys     = y_q >>> step_q;
		ax     = x_q[VEC_W-1] ? -x_q : x_q;
		ay     = y_q[VEC_W-1] ? -y_q : y_q;
		mag    = (ax > ay) ? ax : ay;
		z_next = (y_q > 0) ? z_q + atan_q30(step_q) : z_q - atan_q30(step_q);
		z_rnd  = (z_next + ANG_W'(1 << 14)) >>> 15;
		rem2   = {rem_q[17:0], rad_q[31:30]};
		trial  = {2'b00, root_q, 2'b01};
	end

	assign pop      = (state_q == B_IDLE) && !empty;
	assign load_out = (state_q == B_DONE) && (!out_valid || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						case (job.op)
							OP_MAG:   state_q <= B_SQRT;
							OP_ANGLE: state_q <= (job.a == '0 && job.b == '0) ? B_DONE : B_NORM;
							default:  state_q <= B_DONE;
						endcase
					end
				end
				B_SQRT: if (step_q == 5'd15) state_q <= B_DONE;
				B_NORM: if (mag >= (VEC_W'(1) << 40)) state_q <= B_ROT;
				B_ROT:  if (step_q == 5'(STEPS - 1)) state_q <= B_DONE;
				B_DONE: if (load_out) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				step_q <= '0;
				rad_q  <= job.a[31:0];
				rem_q  <= '0;
				root_q <= '0;
				res_q  <= job.op == OP_PASS ? job.a[OUT_W-1:0] : '0;
				if (job.a[OPND_W-1]) begin
					x_q <= -VEC_W'(job.a);
					y_q <= -VEC_W'(job.b);
					z_q <= job.b[OPND_W-1] ? -PI_Q30 : PI_Q30;
				end else begin
					x_q <= VEC_W'(job.a);
					y_q <= VEC_W'(job.b);
					z_q <= '0;
				end
			end
			B_SQRT: begin
				step_q <= step_q + 5'd1;
				rad_q  <= rad_q << 2;
				if (rem2 >= trial) begin
					rem_q  <= rem2 - trial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem2;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				if (step_q == 5'd15) begin
					if (rem2 >= trial) begin
						res_q <= OUT_W'({root_q[ROOT_W-2:0], 1'b1})
							+ OUT_W'((rem2 - trial) > 20'({root_q[ROOT_W-2:0], 1'b1}));
					end else begin
						res_q <= OUT_W'({root_q[ROOT_W-2:0], 1'b0})
							+ OUT_W'(rem2 > 20'({root_q[ROOT_W-2:0], 1'b0}));
					end
				end
			end
			B_NORM: begin
				if (mag < (VEC_W'(1) << 32)) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (mag < (VEC_W'(1) << 40)) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			B_ROT: begin
				step_q <= step_q + 5'd1;
				z_q    <= z_next;
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
				end
				if (step_q == 5'(STEPS - 1)) res_q <= z_rnd[OUT_W-1:0];
			end
			default: ;
		endcase
	end

	// output register and block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pos_q     <= '0;
		end else begin
			if (load_out) begin
				out_valid <= 1'b1;
				pos_q     <= (pos_q == LAST_POS) ? '0 : pos_q + CNT_W'(1);
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (cfg_we) pos_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data <= res_q;
			out_last <= (pos_q == LAST_POS);
		end
	end

endmodule
